FILE: rtl/box_overlap_suppression_core_defines.svh
// ----------------------------------------------------------------------------
// box overlap suppression assertion macros
// shared property wrappers, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef BOX_OVERLAP_SUPPRESSION_CORE_DEFINES_SVH
`define BOX_OVERLAP_SUPPRESSION_CORE_DEFINES_SVH

// same-cycle implication
`define BOS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bos_pkg.sv
// ----------------------------------------------------------------------------
// bos_pkg
// fixed field widths, register indexes, reset values, scale constants and state codes
// ----------------------------------------------------------------------------
`default_nettype none

package bos_pkg;

  localparam int THRESH_W   = 10;
  localparam int LIMIT_W    = 7;
  localparam int TOTAL_W    = 9;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_THRESH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_LIMIT   = 1'd1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd355;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd9;

  // overlap ratio is in thousandths, aspect limit in tenths
  localparam logic [9:0] OVERLAP_SCALE = 10'd1000;
  localparam logic [3:0] ASPECT_SCALE  = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/box_overlap_suppression_core.sv
// ----------------------------------------------------------------------------
// box_overlap_suppression_core
// greedy overlap suppression of candidate boxes against a kept-box memory
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, new_image, box x/y/w/h | sink
//  out     | out_valid/out_ready, kept, tall, total,   | source
//          | table_full                                |
//  cfg     | cfg_we, cfg_index, cfg_wdata              | sink
//
//  during an item's scan the single read port of the kept-box memory reads one
//  stored box per cycle, none on an empty table, then the five stages drain
//  rst_n is synchronous; it empties the table and loads the register defaults,
//  the memory itself is not cleared, entries at or above the count are never read
//  a finished item waits in the output register, the next item can be accepted
//  meanwhile but its result holds in the finish state until the output frees up
//
`default_nettype none

`include "box_overlap_suppression_core_defines.svh"

module box_overlap_suppression_core #(
  parameter int MAX_KEPT   = 256,
  parameter int COORD_BITS = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_new_image,
  input  wire logic [COORD_BITS-1:0]         in_box_x,
  input  wire logic [COORD_BITS-1:0]         in_box_y,
  input  wire logic [COORD_BITS:0]           in_box_w,
  input  wire logic [COORD_BITS:0]           in_box_h,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_kept,
  output logic                               out_tall,
  output logic [bos_pkg::TOTAL_W-1:0]        out_kept_total,
  output logic                               out_table_full,

  input  wire logic                          cfg_we,
  input  wire logic [bos_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bos_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import bos_pkg::*;

  // widths that follow from the coordinate size
  localparam int CW    = COORD_BITS;
  localparam int SW    = COORD_BITS + 1;        // width / height
  localparam int EW    = COORD_BITS + 2;        // right edge, clamped overlap side
  localparam int IW    = 2 * EW;                // intersection area
  localparam int AAW   = 2 * SW;                // box area
  localparam int UW    = IW + 1;                // signed union
  localparam int PW    = UW + THRESH_W - 1;     // ratio products
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int ADR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int NSTG  = 5;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [SW-1:0] w;
    logic [SW-1:0] h;
  } entry_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [THRESH_W-1:0] thresh_r;
  logic [LIMIT_W-1:0]  limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OVERLAP_THRESH: thresh_r <= cfg_wdata[THRESH_W-1:0];
        REG_ASPECT_LIMIT:   limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default:            ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r;
  logic [NSTG-1:0]  v_r;
  logic             suppress_r;
  logic             hit;

  logic in_acc, rd_en, scan_done, out_load, keep, room, mem_we;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign rd_en     = (state_r == ST_SCAN) && (rd_idx_r < count_r);
  assign scan_done = (state_r == ST_SCAN) && !(rd_idx_r < count_r) && (v_r == '0);
  assign out_load  = (state_r == ST_FIN) && (!out_valid || out_ready);
  assign keep      = !suppress_r;
  assign room      = (count_r < CNT_W'(MAX_KEPT));
  assign mem_we    = out_load && keep && room;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc)    state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done) state_nxt = ST_FIN;
      ST_FIN:  if (out_load)  state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc && in_new_image) begin
      count_nxt = '0;
    end else if (mem_we) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      rd_idx_r   <= '0;
      v_r        <= '0;
      suppress_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      v_r     <= {v_r[NSTG-2:0], rd_en};
      if (in_acc) begin
        rd_idx_r   <= '0;
        suppress_r <= 1'b0;
      end else begin
        if (rd_en) rd_idx_r <= rd_idx_r + CNT_W'(1);
        if (v_r[NSTG-1] && hit) suppress_r <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // candidate box, held for the whole scan
  // --------------------------------------------------------------------------
  entry_t          cand_r;
  logic [AAW-1:0]  cand_area_r;
  logic [SW+3:0]   tall_lhs_r;
  logic [SW+LIMIT_W-1:0] tall_rhs_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cand_r.x <= in_box_x;
      cand_r.y <= in_box_y;
      cand_r.w <= in_box_w;
      cand_r.h <= in_box_h;
    end
    cand_area_r <= cand_r.w * cand_r.h;
    // aspect products refresh every cycle, settled before the finish state
    tall_lhs_r  <= cand_r.w * ASPECT_SCALE;
    tall_rhs_r  <= cand_r.h * limit_r;
  end

  // --------------------------------------------------------------------------
  // kept-box memory: one write port in the finish state, one registered read
  // port during the scan; the two never overlap since a new item only enters
  // after the write of the previous one
  // --------------------------------------------------------------------------
  entry_t mem [MAX_KEPT];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[ADR_W-1:0]] <= cand_r;
    if (rd_en)  rdata_r <= mem[rd_idx_r[ADR_W-1:0]];
  end

  // --------------------------------------------------------------------------
  // overlap pipeline, one stored box per cycle
  // --------------------------------------------------------------------------
  // stage 1: overlap sides, clamped at zero
  logic [EW-1:0] a_xe, b_xe, a_ye, b_ye, min_xe, min_ye, max_x, max_y;
  logic signed [EW:0] dx, dy;
  logic [EW-1:0] iw1_r, ih1_r;
  logic [SW-1:0] bw1_r, bh1_r;

  always_comb begin
    a_xe   = EW'(cand_r.x) + EW'(cand_r.w);
    b_xe   = EW'(rdata_r.x) + EW'(rdata_r.w);
    a_ye   = EW'(cand_r.y) + EW'(cand_r.h);
    b_ye   = EW'(rdata_r.y) + EW'(rdata_r.h);
    min_xe = (a_xe < b_xe) ? a_xe : b_xe;
    min_ye = (a_ye < b_ye) ? a_ye : b_ye;
    max_x  = (cand_r.x > rdata_r.x) ? EW'(cand_r.x) : EW'(rdata_r.x);
    max_y  = (cand_r.y > rdata_r.y) ? EW'(cand_r.y) : EW'(rdata_r.y);
    // inclusive sides: +1
    dx = $signed({1'b0, min_xe}) - $signed({1'b0, max_x}) + $signed((EW+1)'(1));
    dy = $signed({1'b0, min_ye}) - $signed({1'b0, max_y}) + $signed((EW+1)'(1));
  end

  always_ff @(posedge clk) begin
    iw1_r <= dx[EW] ? '0 : dx[EW-1:0];
    ih1_r <= dy[EW] ? '0 : dy[EW-1:0];
    bw1_r <= rdata_r.w;
    bh1_r <= rdata_r.h;
  end

  // stage 2: intersection and stored area
  logic [IW-1:0]  inner2_r;
  logic [AAW-1:0] area_b2_r;

  always_ff @(posedge clk) begin
    inner2_r  <= iw1_r * ih1_r;
    area_b2_r <= bw1_r * bh1_r;
  end

  // stage 3: union, may go negative
  logic signed [UW-1:0] uni3_r;
  logic [IW-1:0]        inner3_r;

  always_ff @(posedge clk) begin
    uni3_r   <= $signed(UW'(cand_area_r)) + $signed(UW'(area_b2_r))
              - $signed(UW'(inner2_r));
    inner3_r <= inner2_r;
  end

  // stage 4: cross products of the ratio test
  logic [IW+9:0] lhs4_r;
  logic [PW-1:0] rhs4_r;
  logic          uni_pos4_r, uni_zero4_r, inner_nz4_r;

  always_ff @(posedge clk) begin
    lhs4_r      <= inner3_r * OVERLAP_SCALE;
    rhs4_r      <= uni3_r[UW-2:0] * thresh_r;
    uni_pos4_r  <= !uni3_r[UW-1] && (uni3_r != '0);
    uni_zero4_r <= (uni3_r == '0);
    inner_nz4_r <= (inner3_r != '0);
  end

  // stage 5: compare, folded into the suppress flag
  always_comb begin
    priority if (uni_pos4_r) begin
      hit = (PW'(lhs4_r) > rhs4_r);
    end else if (uni_zero4_r) begin
      // degenerate union with any overlap suppresses
      hit = inner_nz4_r;
    end else begin
      hit = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic out_valid_r, out_kept_r, out_tall_r, out_full_r;
  logic [TOTAL_W-1:0] out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kept_r  <= keep;
      out_tall_r  <= keep && ((SW+LIMIT_W)'(tall_lhs_r) <= tall_rhs_r);
      out_full_r  <= keep && !room;
      out_total_r <= TOTAL_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kept       = out_kept_r;
  assign out_tall       = out_tall_r;
  assign out_kept_total = out_total_r;
  assign out_table_full = out_full_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `BOS_ASSERT_NOW(a_idle_pipe_empty, in_ready, v_r == '0,
    "overlap pipeline busy while taking a new item")
  `BOS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_KEPT),
    "kept count beyond table depth")
  `BOS_ASSERT_NOW(a_full_means_kept, out_valid && out_table_full, out_kept,
    "table_full reported on a dropped item")
  `BOS_ASSERT_NEXT(a_load_to_idle, out_load, in_ready && out_valid,
    "result load did not return to idle")
  `BOS_ASSERT_NOW(a_no_read_on_write, mem_we, !rd_en,
    "memory written during a scan")

endmodule

`default_nettype wire
